// ----- design/vrtc_pkg.sv -----
// ----------------------------------------------------------------------------
// vrtc_pkg: shared types and constants of the virtual RTC divider table
// Field widths, the decoded operation codes and the result record.
// ----------------------------------------------------------------------------
package vrtc_pkg;

  localparam int unsigned CMD_W     = 3;
  localparam int unsigned SLOT_W    = 3;
  localparam int unsigned RATE_HZ_W = 16;
  localparam int unsigned LEN_W     = 8;
  localparam int unsigned MASK_W    = 8;
  localparam int unsigned CNT_W     = 10;
  // A clamped rate and the divider quotient never exceed 1024.
  localparam int unsigned RATE_W    = 11;

  localparam logic [CNT_W-1:0] COUNT_MAX = 10'd1023;
  localparam logic [LEN_W-1:0] LEN_OK    = 8'd4;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_BAD_LEN = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK     = 3'd0,
    CMD_OPEN     = 3'd1,
    CMD_CLOSE    = 3'd2,
    CMD_SET_RATE = 3'd3,
    CMD_ARM      = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_OPEN,
    OP_CLOSE,
    OP_SET_RATE,
    OP_ARM,
    OP_BAD_LEN,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [SLOT_W-1:0]  slot;
    logic [RATE_W-1:0]  rate;
  } op_t;

  typedef struct packed {
    logic               status;
    logic [MASK_W-1:0]  trigger_mask;
    logic [MASK_W-1:0]  fired_mask;
  } result_t;

endpackage

// ----- design/vrtc_req_if.sv -----
// ----------------------------------------------------------------------------
// vrtc_req_if: request channel of the virtual RTC divider table
// Valid/ready handshake carrying one command.
// ----------------------------------------------------------------------------
interface vrtc_req_if;
  logic                             valid;
  logic                             ready;
  logic [vrtc_pkg::CMD_W-1:0]       cmd;
  logic [vrtc_pkg::SLOT_W-1:0]      slot;
  logic [vrtc_pkg::RATE_HZ_W-1:0]   rate_hz;
  logic [vrtc_pkg::LEN_W-1:0]       byte_count;

  modport source (output valid, cmd, slot, rate_hz, byte_count, input ready);
  modport sink   (input valid, cmd, slot, rate_hz, byte_count, output ready);
endinterface

// ----- design/vrtc_rsp_if.sv -----
// ----------------------------------------------------------------------------
// vrtc_rsp_if: response channel of the virtual RTC divider table
// Valid/ready handshake carrying one result per request.
// ----------------------------------------------------------------------------
interface vrtc_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          status;
  logic [vrtc_pkg::MASK_W-1:0]   trigger_mask;
  logic [vrtc_pkg::MASK_W-1:0]   fired_mask;

  modport source (output valid, status, trigger_mask, fired_mask, input ready);
  modport sink   (input valid, status, trigger_mask, fired_mask, output ready);
endinterface

// ----- design/vrtc_front.sv -----
// ----------------------------------------------------------------------------
// vrtc_front: request decoder and operation queue
// Classifies each request, clamps the rate and queues it for the back end.
// ----------------------------------------------------------------------------
module vrtc_front #(
  parameter int unsigned SLOTS    = 6,
  parameter int unsigned MAX_RATE = 1024,
  parameter int unsigned MIN_RATE = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  vrtc_req_if.sink          req_i,
  output logic              op_valid_o,
  output vrtc_pkg::op_t     op_o,
  input  logic              op_ready_i
);

  localparam int unsigned HZW = vrtc_pkg::RATE_HZ_W;
  localparam logic [HZW-1:0] MAX_HZ = MAX_RATE[HZW-1:0];
  localparam logic [HZW-1:0] MIN_HZ = MIN_RATE[HZW-1:0];
  localparam logic [vrtc_pkg::SLOT_W:0] SLOT_LIMIT = SLOTS[vrtc_pkg::SLOT_W:0];

  vrtc_pkg::op_t   dec_op;
  logic            slot_ok;
  logic [HZW-1:0]  rate_hi;
  logic [HZW-1:0]  rate_lo;

  vrtc_pkg::op_t   entry_q [2];
  logic            wr_q;
  logic            rd_q;
  logic [1:0]      cnt_q;
  logic            push;
  logic            pop;

  // Decode
  always_comb begin
    slot_ok = {1'b0, req_i.slot} < SLOT_LIMIT;
    rate_hi = (req_i.rate_hz > MAX_HZ) ? MAX_HZ : req_i.rate_hz;
    rate_lo = (rate_hi < MIN_HZ) ? MIN_HZ : rate_hi;

    dec_op.slot = req_i.slot;
    dec_op.rate = rate_lo[vrtc_pkg::RATE_W-1:0];
    dec_op.op   = vrtc_pkg::OP_NOP;
    unique case (req_i.cmd)
      vrtc_pkg::CMD_TICK: begin
        dec_op.op = vrtc_pkg::OP_TICK;
      end
      vrtc_pkg::CMD_OPEN: begin
        if (slot_ok) dec_op.op = vrtc_pkg::OP_OPEN;
      end
      vrtc_pkg::CMD_CLOSE: begin
        if (slot_ok) dec_op.op = vrtc_pkg::OP_CLOSE;
      end
      vrtc_pkg::CMD_SET_RATE: begin
        // The length check wins over the slot check.
        if (req_i.byte_count != vrtc_pkg::LEN_OK) begin
          dec_op.op = vrtc_pkg::OP_BAD_LEN;
        end else if (slot_ok) begin
          dec_op.op = vrtc_pkg::OP_SET_RATE;
        end
      end
      vrtc_pkg::CMD_ARM: begin
        if (slot_ok) dec_op.op = vrtc_pkg::OP_ARM;
      end
      default: begin
        dec_op.op = vrtc_pkg::OP_NOP;
      end
    endcase
  end

  // Two-entry queue
  assign req_i.ready = (cnt_q != 2'd2);
  assign push        = req_i.valid && req_i.ready;
  assign op_valid_o  = (cnt_q != 2'd0);
  assign op_o        = entry_q[rd_q];
  assign pop         = op_valid_o && op_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) entry_q[wr_q] <= dec_op;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1 && push && !pop) |=> (cnt_q == 2'd2 && !req_i.ready))
    else $error("vrtc_front: queue fill count lost a request");

endmodule

// ----- design/vrtc_div.sv -----
// ----------------------------------------------------------------------------
// vrtc_div: iterative restoring divider
// Produces one quotient bit per cycle; done pulses when the quotient is ready.
// ----------------------------------------------------------------------------
module vrtc_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [vrtc_pkg::RATE_W-1:0]   dividend_i,
  input  logic [vrtc_pkg::RATE_W-1:0]   divisor_i,
  output logic                          done_o,
  output logic [vrtc_pkg::RATE_W-1:0]   quotient_o
);

  localparam int unsigned W      = vrtc_pkg::RATE_W;
  localparam int unsigned STEP_W = $clog2(W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(W - 1);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic [W-1:0]      rem_q;
  logic [W-1:0]      quo_q;
  logic [W-1:0]      dvs_q;
  logic [W-1:0]      rem_sh;
  logic              take;

  // The remainder stays below the divisor, so its top bit is always clear.
  always_comb begin
    rem_sh = {rem_q[W-2:0], quo_q[W-1]};
    take   = (rem_sh >= dvs_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= busy_q && !start_i && (step_q == LAST_STEP);
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == LAST_STEP) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= take ? (rem_sh - dvs_q) : rem_sh;
      quo_q <= {quo_q[W-2:0], take};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- design/vrtc_back.sv -----
// ----------------------------------------------------------------------------
// vrtc_back: slot table and command execution
// Holds the per-slot dividers, runs queued operations and registers results.
// ----------------------------------------------------------------------------
module vrtc_back #(
  parameter int unsigned SLOTS    = 6,
  parameter int unsigned MAX_RATE = 1024,
  parameter int unsigned MIN_RATE = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              op_valid_i,
  input  vrtc_pkg::op_t     op_i,
  output logic              op_ready_o,
  vrtc_rsp_if.source        rsp_o
);

  localparam int unsigned CW = vrtc_pkg::CNT_W;
  localparam int unsigned SW = vrtc_pkg::SLOT_W;
  localparam int unsigned RW = vrtc_pkg::RATE_W;
  localparam int unsigned OPEN_Q = MAX_RATE / MIN_RATE;
  localparam logic [CW-1:0] OPEN_DIV = (OPEN_Q > 1023) ? vrtc_pkg::COUNT_MAX : CW'(OPEN_Q);
  localparam logic [RW-1:0] DIVIDEND = MAX_RATE[RW-1:0];

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_WRITE
  } state_e;

  state_e                       state_q;
  logic                         out_valid_q;
  vrtc_pkg::result_t            out_res_q;
  logic [SW-1:0]                slot_q;
  logic [CW-1:0]                qsat_q;

  logic [CW-1:0]                div_q  [SLOTS];
  logic [CW-1:0]                cnt_q  [SLOTS];
  logic                         trig_q [SLOTS];
  logic [CW-1:0]                div_d  [SLOTS];
  logic [CW-1:0]                cnt_d  [SLOTS];
  logic                         trig_d [SLOTS];

  logic                         out_free;
  logic                         pop;
  logic                         div_start;
  logic                         div_done;
  logic [RW-1:0]                quotient;
  logic                         commit;
  logic                         res_load;
  logic [CW-1:0]                cnt_inc;
  logic [vrtc_pkg::MASK_W-1:0]  fired;
  logic [vrtc_pkg::MASK_W-1:0]  mask_d;
  vrtc_pkg::result_t            res_d;

  assign out_free   = !out_valid_q || rsp_o.ready;
  assign op_ready_o = (state_q == ST_IDLE) && out_free;
  assign pop        = op_valid_i && op_ready_o;
  assign div_start  = pop && (op_i.op == vrtc_pkg::OP_SET_RATE);
  assign commit     = (state_q == ST_WRITE) && out_free;
  assign res_load   = (pop && (op_i.op != vrtc_pkg::OP_SET_RATE)) || commit;

  vrtc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (DIVIDEND),
    .divisor_i  (op_i.rate),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Next slot table, one lane per slot
  always_comb begin
    fired   = '0;
    cnt_inc = '0;
    for (int i = 0; i < SLOTS; i++) begin
      div_d[i]  = div_q[i];
      cnt_d[i]  = cnt_q[i];
      trig_d[i] = trig_q[i];
    end
    if (pop) begin
      unique case (op_i.op)
        vrtc_pkg::OP_TICK: begin
          for (int i = 0; i < SLOTS; i++) begin
            cnt_inc = cnt_q[i] + 1'b1;
            if (div_q[i] != '0) begin
              if (cnt_inc >= div_q[i]) begin
                trig_d[i] = 1'b1;
                cnt_d[i]  = '0;
                fired[i]  = 1'b1;
              end else begin
                cnt_d[i] = cnt_inc;
              end
            end
          end
        end
        vrtc_pkg::OP_OPEN: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (op_i.slot == SW'(i)) begin
              cnt_d[i]  = '0;
              div_d[i]  = OPEN_DIV;
              trig_d[i] = 1'b0;
            end
          end
        end
        vrtc_pkg::OP_CLOSE: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (op_i.slot == SW'(i)) begin
              cnt_d[i]  = '0;
              div_d[i]  = '0;
              trig_d[i] = 1'b0;
            end
          end
        end
        vrtc_pkg::OP_ARM: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (op_i.slot == SW'(i)) trig_d[i] = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
    if (commit) begin
      // A set rate keeps the trigger and restarts the counter.
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_q == SW'(i)) begin
          div_d[i] = qsat_q;
          cnt_d[i] = '0;
        end
      end
    end

    mask_d = '0;
    for (int i = 0; i < SLOTS; i++) begin
      mask_d[i] = trig_d[i];
    end
    res_d.status       = (pop && op_i.op == vrtc_pkg::OP_BAD_LEN) ?
                         vrtc_pkg::STATUS_BAD_LEN : vrtc_pkg::STATUS_OK;
    res_d.trigger_mask = mask_d;
    res_d.fired_mask   = fired;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        div_q[i]  <= '0;
        cnt_q[i]  <= '0;
        trig_q[i] <= 1'b0;
      end
    end else begin
      for (int i = 0; i < SLOTS; i++) begin
        div_q[i]  <= div_d[i];
        cnt_q[i]  <= cnt_d[i];
        trig_q[i] <= trig_d[i];
      end
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_res_q   <= '0;
      slot_q      <= '0;
      qsat_q      <= '0;
    end else begin
      if (res_load) begin
        out_valid_q <= 1'b1;
        out_res_q   <= res_d;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (pop) begin
            slot_q <= op_i.slot;
            if (op_i.op == vrtc_pkg::OP_SET_RATE) begin
              state_q <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            qsat_q  <= quotient[RW-1] ? vrtc_pkg::COUNT_MAX : quotient[CW-1:0];
            state_q <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          if (commit) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_res_q.status;
  assign rsp_o.trigger_mask = out_res_q.trigger_mask;
  assign rsp_o.fired_mask   = out_res_q.fired_mask;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("vrtc_back: divider finished outside a set-rate operation");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && op_i.op != vrtc_pkg::OP_SET_RATE) |=> out_valid_q)
    else $error("vrtc_back: immediate operation produced no result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_res_q.trigger_mask >> SLOTS) == '0))
    else $error("vrtc_back: trigger reported for a slot that does not exist");

  for (genvar g = 0; g < SLOTS; g++) begin : g_lane_chk
    assert property (@(posedge clk_i) disable iff (!rst_ni)
      (div_q[g] == '0) |-> (cnt_q[g] == '0))
      else $error("vrtc_back: closed slot has a running counter");
  end

endmodule

// ----- design/virtual_rtc_rate_dividers_top.sv -----
// ----------------------------------------------------------------------------
// virtual_rtc_rate_dividers_top: per-process virtual RTC divider table
// Requests (tick, open, close, set rate, arm) go in on req_i; each request
// gives exactly one result on rsp_o: a status bit, the trigger mask after
// the request and the mask of slots that wrapped on a tick.
// A decoder queues up to two classified requests ahead of the executing
// back end. Tick, open, close, arm and rejected requests get their result
// registered when the back end takes them from the queue, one per cycle
// while the output register is free. Set rate runs an 11-step iterative
// divider for MAX_RATE / rate, writes the saturated quotient to the slot
// and the result to the output register, and no other request starts
// until the sequencer is idle again. At reset every slot is closed, all
// counters and triggers are cleared and req_i.ready is high. When the
// receiver holds off rsp_o.ready, the result waits in the output register,
// the back end stops and the queue fills, after which req_i.ready drops.
// ----------------------------------------------------------------------------
module virtual_rtc_rate_dividers_top #(
  parameter int unsigned SLOTS    = 6,
  parameter int unsigned MAX_RATE = 1024,
  parameter int unsigned MIN_RATE = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  vrtc_req_if.sink      req_i,
  vrtc_rsp_if.source    rsp_o
);

  logic           op_valid;
  logic           op_ready;
  vrtc_pkg::op_t  op;

  vrtc_front #(
    .SLOTS    (SLOTS),
    .MAX_RATE (MAX_RATE),
    .MIN_RATE (MIN_RATE)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .op_valid_o (op_valid),
    .op_o       (op),
    .op_ready_i (op_ready)
  );

  vrtc_back #(
    .SLOTS    (SLOTS),
    .MAX_RATE (MAX_RATE),
    .MIN_RATE (MIN_RATE)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (op_valid),
    .op_i       (op),
    .op_ready_o (op_ready),
    .rsp_o      (rsp_o)
  );

endmodule

// ----- dv/virtual_rtc_rate_dividers_top_test.sv -----
// ----------------------------------------------------------------------------
// virtual_rtc_rate_dividers_top_test: testbench of the virtual RTC divider table
// Drives tick, open, close, set rate and arm requests. A short directed table
// comes first, then a long random mix that is weighted toward ticks and fast
// rates so that the slots fire often. Typed directed rows give their result;
// a local slot-table model predicts the rest. Both sides of the handshake idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module virtual_rtc_rate_dividers_top_test;
  import vrtc_pkg::*;

  localparam int unsigned SLOTS        = 6;
  localparam int unsigned MAX_RATE     = 1024;
  localparam int unsigned MIN_RATE     = 2;
  localparam int unsigned SLOT_CAP     = 8;
  localparam int unsigned RANDOM_ITEMS = 1575;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned MAX_REPORTS  = 10;

  // Command codes that the block does not decode.
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [CMD_W-1:0]     cmd;
    logic [SLOT_W-1:0]    slot;
    logic [RATE_HZ_W-1:0] rate_hz;
    logic [LEN_W-1:0]     byte_count;
  } vrtc_cmd_t;

  typedef struct packed {
    vrtc_cmd_t req;
    logic      typed;
    result_t   want;
  } directed_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  vrtc_req_if req_if ();
  vrtc_rsp_if rsp_if ();

  virtual_rtc_rate_dividers_top #(
    .SLOTS    (SLOTS),
    .MAX_RATE (MAX_RATE),
    .MIN_RATE (MIN_RATE)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #10 clk_i = ~clk_i;

  // Slot table as the block should hold it.
  logic [CNT_W-1:0] slot_divide  [SLOT_CAP];
  logic [CNT_W-1:0] slot_count   [SLOT_CAP];
  logic             slot_trigger [SLOT_CAP];

  result_t       pending_results [$];
  directed_row_t directed_rows [$];
  int unsigned   mismatch_count;
  int unsigned   src_idle_pct;
  int unsigned   snk_idle_pct;

  function automatic logic [CNT_W-1:0] divide_for_rate(input int unsigned rate);
    int unsigned r;
    int unsigned q;
    r = rate;
    if (r > MAX_RATE) r = MAX_RATE;
    if (r < MIN_RATE) r = MIN_RATE;
    if (r == 0) r = 1;
    q = MAX_RATE / r;
    if (q > COUNT_MAX) q = COUNT_MAX;
    return q[CNT_W-1:0];
  endfunction

  function automatic result_t predict_command(input vrtc_cmd_t c);
    result_t r;
    logic    slot_ok;
    r = '0;
    slot_ok = (c.slot < SLOTS);
    case (c.cmd)
      CMD_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_divide[i] != '0) begin
            slot_count[i] = slot_count[i] + 1'b1;
            if (slot_count[i] >= slot_divide[i]) begin
              slot_trigger[i] = 1'b1;
              slot_count[i] = '0;
              r.fired_mask[i] = 1'b1;
            end
          end
        end
      end
      CMD_OPEN: begin
        if (slot_ok) begin
          slot_count[c.slot] = '0;
          slot_divide[c.slot] = divide_for_rate(MIN_RATE);
          slot_trigger[c.slot] = 1'b0;
        end
      end
      CMD_CLOSE: begin
        if (slot_ok) begin
          slot_count[c.slot] = '0;
          slot_divide[c.slot] = '0;
          slot_trigger[c.slot] = 1'b0;
        end
      end
      CMD_SET_RATE: begin
        // The length check wins over the slot check.
        if (c.byte_count != LEN_OK) begin
          r.status = STATUS_BAD_LEN;
        end else if (slot_ok) begin
          slot_divide[c.slot] = divide_for_rate(c.rate_hz);
          slot_count[c.slot] = '0;
        end
      end
      CMD_ARM: begin
        if (slot_ok) slot_trigger[c.slot] = 1'b0;
      end
      default: ;
    endcase
    for (int i = 0; i < SLOTS; i++) r.trigger_mask[i] = slot_trigger[i];
    return r;
  endfunction

  function automatic void add_row(input logic [CMD_W-1:0] cmd, input int unsigned slot,
                                  input int unsigned rate, input int unsigned len,
                                  input logic typed, input logic status,
                                  input int unsigned trig, input int unsigned fired);
    directed_row_t row;
    row.req.cmd = cmd;
    row.req.slot = SLOT_W'(slot);
    row.req.rate_hz = RATE_HZ_W'(rate);
    row.req.byte_count = LEN_W'(len);
    row.typed = typed;
    row.want.status = status;
    row.want.trigger_mask = MASK_W'(trig);
    row.want.fired_mask = MASK_W'(fired);
    directed_rows.push_back(row);
  endfunction

  function automatic vrtc_cmd_t random_command();
    vrtc_cmd_t   c;
    int unsigned pick;
    int unsigned rate_pick;
    c.rate_hz = RATE_HZ_W'($urandom);
    c.byte_count = LEN_W'($urandom);
    c.slot = ($urandom_range(99) < 85) ? SLOT_W'($urandom_range(SLOTS - 1))
                                        : SLOT_W'($urandom_range(SLOT_CAP - 1));
    pick = $urandom_range(99);
    if (pick < 45) begin
      c.cmd = CMD_TICK;
    end else if (pick < 60) begin
      c.cmd = CMD_SET_RATE;
      c.byte_count = LEN_OK;
      // Mostly fast rates, so that the small divide counts fire within a few ticks.
      rate_pick = $urandom_range(99);
      if (rate_pick < 50) begin
        c.rate_hz = RATE_HZ_W'($urandom_range(MAX_RATE, MAX_RATE / 16));
      end else if (rate_pick < 70) begin
        c.rate_hz = RATE_HZ_W'($urandom);
      end else if (rate_pick < 85) begin
        c.rate_hz = RATE_HZ_W'($urandom_range(MIN_RATE + 1, 0));
      end else begin
        c.rate_hz = RATE_HZ_W'($urandom_range(MAX_RATE + 80, MAX_RATE - 8));
      end
    end else if (pick < 65) begin
      c.cmd = CMD_SET_RATE;
    end else if (pick < 75) begin
      c.cmd = CMD_OPEN;
    end else if (pick < 83) begin
      c.cmd = CMD_CLOSE;
    end else if (pick < 93) begin
      c.cmd = CMD_ARM;
    end else if (pick < 97) begin
      c.cmd = CMD_W'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
    end else begin
      c.cmd = CMD_W'($urandom_range(7));
    end
    return c;
  endfunction

  // Presents one request, waits for it to be taken and queues its result.
  task automatic send_request(input vrtc_cmd_t c, input logic typed, input result_t want);
    result_t predicted;
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.cmd <= c.cmd;
    req_if.slot <= c.slot;
    req_if.rate_hz <= c.rate_hz;
    req_if.byte_count <= c.byte_count;
    do @(posedge clk_i); while (!req_if.ready);
    predicted = predict_command(c);
    pending_results.push_back(typed ? want : predicted);
  endtask

  always @(posedge clk_i) begin : rsp_check
    result_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: status=%0d trigger=%h fired=%h",
                   rsp_if.status, rsp_if.trigger_mask, rsp_if.fired_mask);
      end else begin
        want = pending_results.pop_front();
        if (rsp_if.status !== want.status || rsp_if.trigger_mask !== want.trigger_mask ||
            rsp_if.fired_mask !== want.fired_mask) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("mismatch: exp status=%0d trigger=%h fired=%h, got status=%0d trigger=%h fired=%h",
                     want.status, want.trigger_mask, want.fired_mask,
                     rsp_if.status, rsp_if.trigger_mask, rsp_if.fired_mask);
        end
      end
    end
    rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  initial begin
    #(20_000_000);
    $display("status: fail");
    $finish;
  end

  initial begin
    result_t none;
    none = '0;
    mismatch_count = 0;
    src_idle_pct = 22;
    snk_idle_pct = 49;
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.cmd = CMD_TICK;
    req_if.slot = '0;
    req_if.rate_hz = '0;
    req_if.byte_count = '0;
    rsp_if.ready = 1'b0;
    for (int i = 0; i < SLOT_CAP; i++) begin
      slot_divide[i] = '0;
      slot_count[i] = '0;
      slot_trigger[i] = 1'b0;
    end

    // cmd, slot, rate, length, typed, status, trigger mask, fired mask
    add_row(CMD_TICK,      0,     0,   0, 1, STATUS_OK,      'h00, 'h00);
    add_row(CMD_SET_RATE,  0,  1024,   4, 1, STATUS_OK,      'h00, 'h00);
    add_row(CMD_SET_RATE,  1,     5,   3, 1, STATUS_BAD_LEN, 'h00, 'h00);
    add_row(CMD_SET_RATE,  7, 65535, 255, 1, STATUS_BAD_LEN, 'h00, 'h00);
    add_row(CMD_TICK,      0,     0,   0, 1, STATUS_OK,      'h01, 'h01);
    add_row(CMD_OPEN,      5,     0,   0, 0, STATUS_OK,      'h00, 'h00);
    add_row(CMD_SET_RATE,  2,     0,   4, 0, STATUS_OK,      'h00, 'h00);
    add_row(CMD_SET_RATE,  3, 65535,   4, 0, STATUS_OK,      'h00, 'h00);
    add_row(CMD_SET_RATE,  6,  1024,   4, 1, STATUS_OK,      'h01, 'h00);
    add_row(CMD_OPEN,      7,     0,   0, 1, STATUS_OK,      'h01, 'h00);
    add_row(CMD_TICK,      0,     0,   0, 0, STATUS_OK,      'h00, 'h00);
    add_row(CMD_ARM,       0,     0,   0, 0, STATUS_OK,      'h00, 'h00);
    add_row(CMD_ARM,       6,     0,   0, 0, STATUS_OK,      'h00, 'h00);
    add_row(CMD_UNUSED_LO, 0,     0,   4, 1, STATUS_OK,      'h08, 'h00);
    add_row(CMD_UNUSED_HI, 7, 65535, 255, 1, STATUS_OK,      'h08, 'h00);
    add_row(CMD_CLOSE,     3,     0,   0, 0, STATUS_OK,      'h00, 'h00);
    add_row(CMD_CLOSE,     6,     0,   0, 0, STATUS_OK,      'h00, 'h00);
    add_row(CMD_SET_RATE,  4,   512,   4, 0, STATUS_OK,      'h00, 'h00);
    add_row(CMD_TICK,      0,     0,   0, 0, STATUS_OK,      'h00, 'h00);
    add_row(CMD_TICK,      0,     0,   0, 0, STATUS_OK,      'h00, 'h00);
    add_row(CMD_SET_RATE,  1,     3,   4, 0, STATUS_OK,      'h00, 'h00);
    add_row(CMD_SET_RATE,  4,  1023,   4, 0, STATUS_OK,      'h00, 'h00);
    add_row(CMD_ARM,       4,     0,   0, 0, STATUS_OK,      'h00, 'h00);
    add_row(CMD_UNUSED_LO + 3'd1, 2, 0, 0, 0, STATUS_OK,     'h00, 'h00);
    add_row(CMD_SET_RATE,  5, 32768,   0, 1, STATUS_BAD_LEN, 'h01, 'h00);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        src_idle_pct = 49;
        snk_idle_pct = 22;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      send_request(random_command(), 1'b0, none);
    end
    req_if.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/vrtc_pkg.sv
design/vrtc_req_if.sv
design/vrtc_rsp_if.sv
design/vrtc_front.sv
design/vrtc_div.sv
design/vrtc_back.sv
design/virtual_rtc_rate_dividers_top.sv
dv/virtual_rtc_rate_dividers_top_test.sv
